FILE: rtl/mcbpp_pkg.sv
// ----------------------------------------------------------------------------
// mcbpp_pkg
// shared sizes, codes, command type and helpers for the byte pipe pool
// ----------------------------------------------------------------------------
package mcbpp_pkg;

    // pool geometry
    localparam int PIPE_COUNT     = 32;
    localparam int BUFFER_DEPTH   = 4096;
    localparam int MAX_READ_BURST = 64;

    // fixed field widths
    localparam int REQ_W    = 2;
    localparam int DESC_W   = 6;
    localparam int BYTE_W   = 8;
    localparam int LEN_W    = 7;
    localparam int STATUS_W = 3;
    localparam int ID_W     = 5;

    // derived widths
    localparam int PIPE_W   = (PIPE_COUNT > 1) ? $clog2(PIPE_COUNT) : 1;
    localparam int ID_EXT_W = (PIPE_W > ID_W) ? PIPE_W : ID_W;
    localparam int PTR_W    = $clog2(BUFFER_DEPTH);
    localparam int FILL_W   = $clog2(BUFFER_DEPTH + 1);
    localparam int SUM_W    = $clog2(2 * BUFFER_DEPTH);
    localparam int CNT_W    = $clog2(MAX_READ_BURST + 1);
    localparam int CMP_W    = (CNT_W > FILL_W) ? CNT_W : FILL_W;
    localparam int STORE_DEPTH = PIPE_COUNT * BUFFER_DEPTH;
    localparam int ADDR_W   = $clog2(STORE_DEPTH);

    // command queue between front and back, power of two deep
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    typedef enum logic [REQ_W-1:0] {
        REQ_CREATE = 2'd0,
        REQ_WRITE  = 2'd1,
        REQ_READ   = 2'd2,
        REQ_CLOSE  = 2'd3
    } t_req;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 3'd0,
        ST_BADFD  = 3'd1,
        ST_BROKEN = 3'd2,
        ST_BLOCK  = 3'd3,
        ST_EOF    = 3'd4,
        ST_NOPIPE = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        CMD_RESP  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_READ  = 2'd2
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind         kind;
        t_status           status;
        logic [ID_W-1:0]   id;
        logic [PIPE_W-1:0] pipe;
        logic [PTR_W-1:0]  ptr;
        logic [BYTE_W-1:0] data;
        logic [CNT_W-1:0]  count;
    } t_cmd;

    // ring pointer advance with wrap at the buffer depth
    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        ptr_inc = (p == PTR_W'(BUFFER_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    // flat byte store address of one pipe slot
    function automatic logic [ADDR_W-1:0] store_addr(input logic [PIPE_W-1:0] pipe,
                                                     input logic [PTR_W-1:0]  ptr);
        store_addr = ADDR_W'(pipe) * ADDR_W'(BUFFER_DEPTH) + ADDR_W'(ptr);
    endfunction

endpackage

FILE: rtl/mcbpp_front.sv
// ----------------------------------------------------------------------------
// mcbpp_front
// accepts requests, checks them against per-pipe state, updates pointers and
// fill counts, and hands a command to the back end
// ----------------------------------------------------------------------------
module mcbpp_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [mcbpp_pkg::REQ_W-1:0]   i_req_type,
    input  logic [mcbpp_pkg::DESC_W-1:0]  i_descriptor,
    input  logic [mcbpp_pkg::BYTE_W-1:0]  i_write_byte,
    input  logic [mcbpp_pkg::LEN_W-1:0]   i_length,
    input  logic                          i_q_full,
    output logic                          o_push,
    output mcbpp_pkg::t_cmd               o_cmd
);

    logic [mcbpp_pkg::PTR_W-1:0]  r_rp   [mcbpp_pkg::PIPE_COUNT];
    logic [mcbpp_pkg::PTR_W-1:0]  r_wp   [mcbpp_pkg::PIPE_COUNT];
    logic [mcbpp_pkg::FILL_W-1:0] r_fill [mcbpp_pkg::PIPE_COUNT];
    logic [mcbpp_pkg::PIPE_COUNT-1:0] r_ropen;
    logic [mcbpp_pkg::PIPE_COUNT-1:0] r_wopen;
    logic [mcbpp_pkg::PIPE_COUNT-1:0] r_alloc;

    logic [mcbpp_pkg::PTR_W-1:0]  n_rp;
    logic [mcbpp_pkg::PTR_W-1:0]  n_wp;
    logic [mcbpp_pkg::FILL_W-1:0] n_fill;
    logic                         n_ropen;
    logic                         n_wopen;
    logic                         n_alloc;
    logic                         st_we;

    logic                             accept;
    logic [mcbpp_pkg::ID_EXT_W-1:0]   id_ext;
    logic                             in_range;
    logic [mcbpp_pkg::PIPE_W-1:0]     idx;
    logic [mcbpp_pkg::PIPE_W-1:0]     tgt;
    logic                             fd_ok;
    logic                             wr_end;
    logic                             free_found;
    logic [mcbpp_pkg::PIPE_W-1:0]     free_idx;
    logic [mcbpp_pkg::LEN_W-1:0]      len_c;
    logic [mcbpp_pkg::CNT_W-1:0]      len_sat;
    logic [mcbpp_pkg::CNT_W-1:0]      rd_n;
    logic [mcbpp_pkg::SUM_W-1:0]      rp_sum;

    assign o_ready = !i_q_full;
    assign accept  = i_valid && !i_q_full;
    assign o_push  = accept;

    // lowest free pipe
    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = mcbpp_pkg::PIPE_COUNT - 1; i >= 0; i--) begin
            if (!r_alloc[i]) begin
                free_found = 1'b1;
                free_idx   = mcbpp_pkg::PIPE_W'(i);
            end
        end
    end

    assign id_ext   = mcbpp_pkg::ID_EXT_W'(i_descriptor[mcbpp_pkg::DESC_W-1:1]);
    assign in_range = {1'b0, id_ext} < (mcbpp_pkg::ID_EXT_W + 1)'(mcbpp_pkg::PIPE_COUNT);
    assign idx      = id_ext[mcbpp_pkg::PIPE_W-1:0];
    assign fd_ok    = in_range && r_alloc[idx];
    assign wr_end   = i_descriptor[0];
    assign tgt      = (mcbpp_pkg::t_req'(i_req_type) == mcbpp_pkg::REQ_CREATE) ? free_idx : idx;

    // burst length: zero counts as one, saturate at the burst limit
    always_comb begin
        if (i_length == '0) begin
            len_c = mcbpp_pkg::LEN_W'(1);
        end else if (i_length > mcbpp_pkg::LEN_W'(mcbpp_pkg::MAX_READ_BURST)) begin
            len_c = mcbpp_pkg::LEN_W'(mcbpp_pkg::MAX_READ_BURST);
        end else begin
            len_c = i_length;
        end
        len_sat = mcbpp_pkg::CNT_W'(len_c);
        rd_n = (mcbpp_pkg::CMP_W'(r_fill[tgt]) < mcbpp_pkg::CMP_W'(len_sat))
             ? mcbpp_pkg::CNT_W'(r_fill[tgt]) : len_sat;
        rp_sum = mcbpp_pkg::SUM_W'(r_rp[tgt]) + mcbpp_pkg::SUM_W'(rd_n);
        if (rp_sum >= mcbpp_pkg::SUM_W'(mcbpp_pkg::BUFFER_DEPTH)) begin
            rp_sum = rp_sum - mcbpp_pkg::SUM_W'(mcbpp_pkg::BUFFER_DEPTH);
        end
    end

    // classification and state update
    always_comb begin
        n_rp    = r_rp[tgt];
        n_wp    = r_wp[tgt];
        n_fill  = r_fill[tgt];
        n_ropen = r_ropen[tgt];
        n_wopen = r_wopen[tgt];
        n_alloc = r_alloc[tgt];
        st_we   = 1'b0;

        o_cmd.kind   = mcbpp_pkg::CMD_RESP;
        o_cmd.status = mcbpp_pkg::ST_OK;
        o_cmd.id     = '0;
        o_cmd.pipe   = tgt;
        o_cmd.ptr    = r_wp[tgt];
        o_cmd.data   = i_write_byte;
        o_cmd.count  = rd_n;

        case (mcbpp_pkg::t_req'(i_req_type))
            mcbpp_pkg::REQ_CREATE: begin
                if (free_found) begin
                    n_rp     = '0;
                    n_wp     = '0;
                    n_fill   = '0;
                    n_ropen  = 1'b1;
                    n_wopen  = 1'b1;
                    n_alloc  = 1'b1;
                    st_we    = 1'b1;
                    o_cmd.id = mcbpp_pkg::ID_W'(free_idx);
                end else begin
                    o_cmd.status = mcbpp_pkg::ST_NOPIPE;
                end
            end
            mcbpp_pkg::REQ_WRITE: begin
                if (!fd_ok || !wr_end) begin
                    o_cmd.status = mcbpp_pkg::ST_BADFD;
                end else if (!r_ropen[tgt]) begin
                    o_cmd.status = mcbpp_pkg::ST_BROKEN;
                end else if (r_fill[tgt] >= mcbpp_pkg::FILL_W'(mcbpp_pkg::BUFFER_DEPTH)) begin
                    o_cmd.status = mcbpp_pkg::ST_BLOCK;
                end else begin
                    o_cmd.kind = mcbpp_pkg::CMD_WRITE;
                    n_wp       = mcbpp_pkg::ptr_inc(r_wp[tgt]);
                    n_fill     = r_fill[tgt] + 1'b1;
                    st_we      = 1'b1;
                end
            end
            mcbpp_pkg::REQ_READ: begin
                if (!fd_ok || wr_end) begin
                    o_cmd.status = mcbpp_pkg::ST_BADFD;
                end else if (r_fill[tgt] == '0) begin
                    o_cmd.status = r_wopen[tgt] ? mcbpp_pkg::ST_BLOCK : mcbpp_pkg::ST_EOF;
                end else begin
                    o_cmd.kind = mcbpp_pkg::CMD_READ;
                    o_cmd.ptr  = r_rp[tgt];
                    n_rp       = mcbpp_pkg::PTR_W'(rp_sum);
                    n_fill     = r_fill[tgt] - mcbpp_pkg::FILL_W'(rd_n);
                    st_we      = 1'b1;
                end
            end
            mcbpp_pkg::REQ_CLOSE: begin
                if (!fd_ok) begin
                    o_cmd.status = mcbpp_pkg::ST_BADFD;
                end else begin
                    if (wr_end) begin
                        n_wopen = 1'b0;
                    end else begin
                        n_ropen = 1'b0;
                    end
                    if (!n_ropen && !n_wopen) begin
                        n_alloc = 1'b0;
                    end
                    st_we = 1'b1;
                end
            end
            default: begin
                o_cmd.status = mcbpp_pkg::ST_BADFD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < mcbpp_pkg::PIPE_COUNT; i++) begin
                r_rp[i]   <= '0;
                r_wp[i]   <= '0;
                r_fill[i] <= '0;
            end
            r_ropen <= '0;
            r_wopen <= '0;
            r_alloc <= '0;
        end else if (accept && st_we) begin
            r_rp[tgt]    <= n_rp;
            r_wp[tgt]    <= n_wp;
            r_fill[tgt]  <= n_fill;
            r_ropen[tgt] <= n_ropen;
            r_wopen[tgt] <= n_wopen;
            r_alloc[tgt] <= n_alloc;
        end
    end

endmodule

FILE: rtl/mcbpp_queue.sv
// ----------------------------------------------------------------------------
// mcbpp_queue
// short command queue between the front and back ends
// ----------------------------------------------------------------------------
module mcbpp_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  mcbpp_pkg::t_cmd i_cmd,
    output logic            o_full,
    input  logic            i_pop,
    output mcbpp_pkg::t_cmd o_head,
    output logic            o_empty
);

    mcbpp_pkg::t_cmd r_mem [mcbpp_pkg::QUEUE_DEPTH];
    logic [mcbpp_pkg::QPTR_W-1:0] r_wr;
    logic [mcbpp_pkg::QPTR_W-1:0] r_rd;
    logic [mcbpp_pkg::QPTR_W:0]   r_cnt;

    assign o_full  = (r_cnt == (mcbpp_pkg::QPTR_W + 1)'(mcbpp_pkg::QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

endmodule

FILE: rtl/mcbpp_back.sv
// ----------------------------------------------------------------------------
// mcbpp_back
// executes queued commands against the byte store and streams result items
// ----------------------------------------------------------------------------
module mcbpp_back (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  mcbpp_pkg::t_cmd                 i_head,
    input  logic                            i_q_empty,
    output logic                            o_pop,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [mcbpp_pkg::STATUS_W-1:0]  o_status,
    output logic [mcbpp_pkg::ID_W-1:0]      o_pipe_id,
    output logic [mcbpp_pkg::BYTE_W-1:0]    o_read_byte,
    output logic                            o_last
);

    logic [mcbpp_pkg::BYTE_W-1:0] mem [mcbpp_pkg::STORE_DEPTH];

    // burst walker
    logic                         r_burst;
    logic [mcbpp_pkg::PIPE_W-1:0] r_b_pipe;
    logic [mcbpp_pkg::PTR_W-1:0]  r_b_ptr;
    logic [mcbpp_pkg::CNT_W-1:0]  r_b_left;

    // stage 1: memory read register
    logic                         r_s1_valid;
    mcbpp_pkg::t_status           r_s1_status;
    logic [mcbpp_pkg::ID_W-1:0]   r_s1_id;
    logic                         r_s1_from_mem;
    logic                         r_s1_last;
    logic [mcbpp_pkg::BYTE_W-1:0] r_s1_rdata;

    // stage 2: output register
    logic                         r_o_valid;
    mcbpp_pkg::t_status           r_o_status;
    logic [mcbpp_pkg::ID_W-1:0]   r_o_id;
    logic [mcbpp_pkg::BYTE_W-1:0] r_o_byte;
    logic                         r_o_last;

    logic                          s2_free;
    logic                          s1_adv;
    logic                          s1_free;
    logic                          issue;
    logic                          pop;
    logic                          mem_re;
    logic                          mem_we;
    logic [mcbpp_pkg::PIPE_W-1:0]  sel_pipe;
    logic [mcbpp_pkg::PTR_W-1:0]   sel_ptr;
    logic [mcbpp_pkg::ADDR_W-1:0]  addr;
    mcbpp_pkg::t_status            iss_status;
    logic [mcbpp_pkg::ID_W-1:0]    iss_id;
    logic                          iss_from_mem;
    logic                          iss_last;
    logic                          start_burst;

    always_comb begin
        s2_free = !r_o_valid || i_ready;
        s1_adv  = r_s1_valid && s2_free;
        s1_free = !r_s1_valid || s1_adv;
        issue   = s1_free && (r_burst || !i_q_empty);
        pop     = s1_free && !r_burst && !i_q_empty;

        mem_re       = 1'b0;
        mem_we       = 1'b0;
        start_burst  = 1'b0;
        iss_status   = mcbpp_pkg::ST_OK;
        iss_id       = '0;
        iss_from_mem = 1'b0;
        iss_last     = 1'b1;

        if (r_burst) begin
            sel_pipe     = r_b_pipe;
            sel_ptr      = r_b_ptr;
            mem_re       = issue;
            iss_from_mem = 1'b1;
            iss_last     = (r_b_left == mcbpp_pkg::CNT_W'(1));
        end else begin
            sel_pipe = i_head.pipe;
            sel_ptr  = i_head.ptr;
            case (i_head.kind)
                mcbpp_pkg::CMD_RESP: begin
                    iss_status = i_head.status;
                    iss_id     = i_head.id;
                end
                mcbpp_pkg::CMD_WRITE: begin
                    mem_we = pop;
                end
                mcbpp_pkg::CMD_READ: begin
                    mem_re       = pop;
                    iss_from_mem = 1'b1;
                    iss_last     = (i_head.count == mcbpp_pkg::CNT_W'(1));
                    start_burst  = pop && !iss_last;
                end
                default: begin
                    iss_status = i_head.status;
                end
            endcase
        end
        addr = mcbpp_pkg::store_addr(sel_pipe, sel_ptr);
    end

    assign o_pop = pop;

    // byte store
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[addr] <= i_head.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_re) begin
            r_s1_rdata <= mem[addr];
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_burst    <= 1'b0;
            r_s1_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            if (r_burst && issue && iss_last) begin
                r_burst <= 1'b0;
            end else if (start_burst) begin
                r_burst <= 1'b1;
            end
            if (issue) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (r_burst && issue) begin
            r_b_ptr  <= mcbpp_pkg::ptr_inc(r_b_ptr);
            r_b_left <= r_b_left - 1'b1;
        end else if (start_burst) begin
            r_b_pipe <= i_head.pipe;
            r_b_ptr  <= mcbpp_pkg::ptr_inc(i_head.ptr);
            r_b_left <= i_head.count - 1'b1;
        end
        if (issue) begin
            r_s1_status   <= iss_status;
            r_s1_id       <= iss_id;
            r_s1_from_mem <= iss_from_mem;
            r_s1_last     <= iss_last;
        end
        if (s1_adv) begin
            r_o_status <= r_s1_status;
            r_o_id     <= r_s1_id;
            r_o_byte   <= r_s1_from_mem ? r_s1_rdata : '0;
            r_o_last   <= r_s1_last;
        end
    end

    assign o_valid     = r_o_valid;
    assign o_status    = r_o_status;
    assign o_pipe_id   = r_o_id;
    assign o_read_byte = r_o_byte;
    assign o_last      = r_o_last;

endmodule

FILE: rtl/multi_channel_byte_pipe_pool.sv
// ----------------------------------------------------------------------------
// multi_channel_byte_pipe_pool
// pool of byte pipes, each a ring buffer with create, write, read and close
// ----------------------------------------------------------------------------
// The front end takes one request item per cycle whenever the command queue
// has room: it checks the descriptor, updates the pipe's pointers, fill count
// and open flags at once, and queues a command. The back end executes one
// command step per cycle against the single-port byte store and delivers one
// result item per cycle while the output is not stalled, so a create, write,
// close or failed read yields one result item and an ok read of n bytes yields
// n items. The first result item of a request passes through the queue and the
// memory read register before the output register; the rest of a burst
// follows one per cycle while the output is not stalled. The byte store is not
// cleared after reset; it needs no clearing pass because a read only returns
// bytes that a write stored.
// ----------------------------------------------------------------------------
module multi_channel_byte_pipe_pool (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // request channel
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [mcbpp_pkg::REQ_W-1:0]     i_req_type,
    input  logic [mcbpp_pkg::DESC_W-1:0]    i_descriptor,
    input  logic [mcbpp_pkg::BYTE_W-1:0]    i_write_byte,
    input  logic [mcbpp_pkg::LEN_W-1:0]     i_length,
    // result channel
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [mcbpp_pkg::STATUS_W-1:0]  o_status,
    output logic [mcbpp_pkg::ID_W-1:0]      o_pipe_id,
    output logic [mcbpp_pkg::BYTE_W-1:0]    o_read_byte,
    output logic                            o_last
);

    // command path between front and back
    logic            q_full;
    logic            q_empty;
    logic            push;
    logic            pop;
    mcbpp_pkg::t_cmd push_cmd;
    mcbpp_pkg::t_cmd head_cmd;

    // classify and update per-pipe state
    mcbpp_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_req_type   (i_req_type),
        .i_descriptor (i_descriptor),
        .i_write_byte (i_write_byte),
        .i_length     (i_length),
        .i_q_full     (q_full),
        .o_push       (push),
        .o_cmd        (push_cmd)
    );

    // decouples request acceptance from result delivery
    mcbpp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_head  (head_cmd),
        .o_empty (q_empty)
    );

    // byte store access and result streaming
    mcbpp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head_cmd),
        .i_q_empty   (q_empty),
        .o_pop       (pop),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_status    (o_status),
        .o_pipe_id   (o_pipe_id),
        .o_read_byte (o_read_byte),
        .o_last      (o_last)
    );

endmodule
